>>> src/cist_pkg.sv
`default_nettype none
package cist_pkg;

  // Table geometry and field widths.
  localparam int SLOT_COUNT = 64;
  localparam int SLOT_W     = 6;
  localparam int CHAN_W     = 8;
  localparam int POS_W      = 48;
  localparam int CNT_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  typedef logic [1:0]        op_t;
  typedef logic [1:0]        kind_t;
  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [CHAN_W-1:0] chan_t;
  typedef logic [POS_W-1:0]  pos_t;

  // Operation codes.
  localparam op_t OP_CLEAR  = 2'd0;
  localparam op_t OP_LOAD   = 2'd1;
  localparam op_t OP_QUERY  = 2'd2;
  localparam op_t OP_UPDATE = 2'd3;

  // Result kinds.
  localparam kind_t KIND_ACK   = 2'd0;
  localparam kind_t KIND_MATCH = 2'd1;
  localparam kind_t KIND_NONE  = 2'd2;

  // Contents of one slot apart from its valid mark.
  typedef struct packed {
    chan_t channel;
    pos_t  start;
    pos_t  stop;
    logic  muted;
    logic  active;
    pos_t  offset;
  } body_t;

  typedef struct packed {
    logic  valid;
    body_t body;
  } rec_t;

  // What the evaluation cell at the head of the ring reports.
  typedef struct packed {
    logic hit;
    rec_t rec;
  } head_t;

endpackage
`default_nettype wire

>>> src/cist_if.sv
`default_nettype none
// Input channel: one word per operation.
interface cist_in_if import cist_pkg::*; ();
  logic  valid;
  logic  ready;
  op_t   operation;
  slot_t slot;
  chan_t channel;
  pos_t  start_sample;
  pos_t  length_samples;
  logic  muted;
  pos_t  position;

  modport source (output valid, operation, slot, channel, start_sample, length_samples,
                  muted, position, input ready);
  modport sink (input valid, operation, slot, channel, start_sample, length_samples,
                muted, position, output ready);
endinterface

// Result channel: one word per result.
interface cist_out_if import cist_pkg::*; ();
  logic  valid;
  logic  ready;
  kind_t kind;
  slot_t match_slot;
  pos_t  play_offset;
  logic  is_playing;
  logic  last;

  modport source (output valid, kind, match_slot, play_offset, is_playing, last,
                  input ready);
  modport sink (input valid, kind, match_slot, play_offset, is_playing, last,
                output ready);
endinterface
`default_nettype wire

>>> src/cist_cell.sv
`default_nettype none
module cist_cell import cist_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic shift_en,
  input  wire logic clr,
  input  wire logic wr_en,
  input  wire rec_t wr_rec,
  input  wire rec_t nbr_rec,
  output rec_t      rec
);

  logic  valid_r;
  body_t body_r;

  // The valid mark is the only part that reset and clear touch.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (clr) begin
      valid_r <= 1'b0;
    end else if (wr_en) begin
      valid_r <= wr_rec.valid;
    end else if (shift_en) begin
      valid_r <= nbr_rec.valid;
    end
  end

  // Slot contents: loaded directly or taken from the neighbor as the ring turns.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      body_r <= wr_rec.body;
    end else if (shift_en) begin
      body_r <= nbr_rec.body;
    end
  end

  assign rec = '{valid: valid_r, body: body_r};

endmodule
`default_nettype wire

>>> src/cist_head.sv
`default_nettype none
module cist_head import cist_pkg::*; (
  input  wire rec_t  cur,
  input  wire logic  query_en,
  input  wire logic  upd_en,
  input  wire chan_t channel,
  input  wire pos_t  position,
  output head_t      res
);

  logic  holds;
  rec_t  nxt;

  // The interval is half open: start <= position < end.
  assign holds = (position >= cur.body.start) && (position < cur.body.stop);

  always_comb begin
    nxt = cur;
    // An update refreshes the active mark and, while active, the offset.
    if (upd_en && cur.valid) begin
      nxt.body.active = holds;
      if (holds) begin
        nxt.body.offset = position - cur.body.start;
      end
    end
  end

  assign res.hit = query_en && cur.valid && !cur.body.muted &&
                   (cur.body.channel == channel) && holds;
  assign res.rec = nxt;

endmodule
`default_nettype wire

>>> src/clip_interval_schedule_table.sv
`default_nettype none
// Clip table of SLOT_COUNT slots kept in a ring of cells that rotates one slot per
// cycle while not stalled, past a single evaluation cell. Clear and load take effect
// in the cycle the word is accepted and answer with one acknowledge word. Query and
// update turn the ring once, then deliver a closing word; a query stalls the ring
// while a further match reaches the head and the result register is still full,
// and the closing word waits until the result register is free. A query returns
// its matches in slot order with last set on the final one, or a single "none"
// word. A new word is accepted only while no operation is in progress and the
// result register is free or being emptied.
module clip_interval_schedule_table import cist_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  cist_in_if.sink    in_chan,
  cist_out_if.source out_chan
);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FLUSH} state_t;

  state_t           state_r;
  logic [CNT_W-1:0] cnt_r;
  logic             is_query_r;
  chan_t            ch_r;
  pos_t             pos_r;

  logic  pend_v_r;
  slot_t pend_slot_r;
  pos_t  pend_off_r;
  logic  pend_play_r;

  logic  o_valid_r;
  kind_t o_kind_r;
  slot_t o_slot_r;
  pos_t  o_off_r;
  logic  o_play_r;
  logic  o_last_r;

  logic  out_free;
  logic  acc;
  logic  stall;
  logic  shift;
  logic  o_load;
  logic  clr_all;
  logic  load_ok;
  rec_t  load_rec;
  head_t head;
  logic  [POS_W:0] sum;

  rec_t cell_q [SLOT_COUNT];

  // Handshake.
  assign out_free      = !o_valid_r || out_chan.ready;
  assign in_chan.ready = (state_r == ST_IDLE) && out_free;
  assign acc           = in_chan.valid && in_chan.ready;

  // A second match waits while the result register is still full.
  assign stall = is_query_r && head.hit && pend_v_r && !out_free;
  assign shift = (state_r == ST_SCAN) && !stall;

  // The result register takes a new word: an acknowledge, a match that is known
  // not to be the final one, or the closing word.
  assign o_load = (acc && (in_chan.operation != OP_QUERY) &&
                   (in_chan.operation != OP_UPDATE)) ||
                  (shift && head.hit && pend_v_r) ||
                  ((state_r == ST_FLUSH) && out_free);

  assign clr_all = acc && (in_chan.operation == OP_CLEAR);
  assign load_ok = acc && (in_chan.operation == OP_LOAD) &&
                   ({1'b0, in_chan.slot} < (SLOT_W + 1)'(SLOT_COUNT));

  // New slot record: end saturates at the largest position.
  assign sum = {1'b0, in_chan.start_sample} + {1'b0, in_chan.length_samples};
  always_comb begin
    load_rec.valid       = 1'b1;
    load_rec.body.channel = in_chan.channel;
    load_rec.body.start  = in_chan.start_sample;
    load_rec.body.stop   = sum[POS_W] ? {POS_W{1'b1}} : sum[POS_W-1:0];
    load_rec.body.muted  = in_chan.muted;
    load_rec.body.active = 1'b0;
    load_rec.body.offset = '0;
  end

  // Evaluation at the head of the ring.
  cist_head u_head (
    .cur      (cell_q[0]),
    .query_en (is_query_r),
    .upd_en   (!is_query_r),
    .channel  (ch_r),
    .position (pos_r),
    .res      (head)
  );

  // Ring of slot cells; the head's record re-enters at the tail.
  for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
    rec_t nbr;
    if (i == SLOT_COUNT - 1) begin : g_tail
      assign nbr = head.rec;
    end else begin : g_mid
      assign nbr = cell_q[i+1];
    end
    cist_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (shift),
      .clr      (clr_all),
      .wr_en    (load_ok && (in_chan.slot == SLOT_W'(i))),
      .wr_rec   (load_rec),
      .nbr_rec  (nbr),
      .rec      (cell_q[i])
    );
  end

  // Sequencer and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cnt_r     <= '0;
      pend_v_r  <= 1'b0;
      o_valid_r <= 1'b0;
    end else begin
      if (o_load) begin
        o_valid_r <= 1'b1;
      end else if (o_valid_r && out_chan.ready) begin
        o_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (acc) begin
            if (in_chan.operation == OP_QUERY || in_chan.operation == OP_UPDATE) begin
              is_query_r <= (in_chan.operation == OP_QUERY);
              ch_r       <= in_chan.channel;
              pos_r      <= in_chan.position;
              cnt_r      <= '0;
              pend_v_r   <= 1'b0;
              state_r    <= ST_SCAN;
            end else begin
              o_kind_r  <= KIND_ACK;
              o_slot_r  <= '0;
              o_off_r   <= '0;
              o_play_r  <= 1'b0;
              o_last_r  <= 1'b1;
            end
          end
        end
        ST_SCAN: begin
          if (shift) begin
            if (head.hit) begin
              // The earlier match is now known not to be the final one.
              if (pend_v_r) begin
                o_kind_r  <= KIND_MATCH;
                o_slot_r  <= pend_slot_r;
                o_off_r   <= pend_off_r;
                o_play_r  <= pend_play_r;
                o_last_r  <= 1'b0;
              end
              pend_v_r    <= 1'b1;
              pend_slot_r <= SLOT_W'(cnt_r);
              pend_off_r  <= cell_q[0].body.offset;
              pend_play_r <= cell_q[0].body.active;
            end
            if (cnt_r == CNT_W'(SLOT_COUNT - 1)) begin
              cnt_r   <= '0;
              state_r <= ST_FLUSH;
            end else begin
              cnt_r <= cnt_r + 1'b1;
            end
          end
        end
        ST_FLUSH: begin
          if (out_free) begin
            o_last_r  <= 1'b1;
            if (is_query_r && pend_v_r) begin
              o_kind_r <= KIND_MATCH;
              o_slot_r <= pend_slot_r;
              o_off_r  <= pend_off_r;
              o_play_r <= pend_play_r;
            end else begin
              o_kind_r <= is_query_r ? KIND_NONE : KIND_ACK;
              o_slot_r <= '0;
              o_off_r  <= '0;
              o_play_r <= 1'b0;
            end
            pend_v_r <= 1'b0;
            state_r  <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_chan.valid       = o_valid_r;
  assign out_chan.kind        = o_kind_r;
  assign out_chan.match_slot  = o_slot_r;
  assign out_chan.play_offset = o_off_r;
  assign out_chan.is_playing  = o_play_r;
  assign out_chan.last        = o_last_r;

endmodule
`default_nettype wire
